[sv/gpiorb_pkg.sv]
// Package for the GPIO register block: command codes, register map, result word type
// and pin-mask helpers used by the register file and the top level.
// Depends on nothing.
package gpiorb_pkg;

  localparam int unsigned PIN_COUNT_DEF = 85;
  localparam int unsigned BANK_CNT      = 3;
  localparam int unsigned FUNC_CNT      = 6;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned ADDR_W        = 5;
  localparam int unsigned BANK_W        = 2;
  localparam int unsigned FUNC_IDX_W    = 3;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  localparam logic [ADDR_W-1:0] ADDR_LEVEL      = 5'd0;
  localparam logic [ADDR_W-1:0] ADDR_LEVEL_LAST = 5'd2;
  localparam logic [ADDR_W-1:0] ADDR_DIR        = 5'd3;
  localparam logic [ADDR_W-1:0] ADDR_DIR_LAST   = 5'd5;
  localparam logic [ADDR_W-1:0] ADDR_SET        = 5'd6;
  localparam logic [ADDR_W-1:0] ADDR_SET_LAST   = 5'd8;
  localparam logic [ADDR_W-1:0] ADDR_CLR        = 5'd9;
  localparam logic [ADDR_W-1:0] ADDR_CLR_LAST   = 5'd11;
  localparam logic [ADDR_W-1:0] ADDR_FUNC       = 5'd21;
  localparam logic [ADDR_W-1:0] ADDR_FUNC_LAST  = 5'd26;
  localparam logic [ADDR_W-1:0] SAMPLE_BANK_LAST = 5'd2;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              bad_address;
    logic [BANK_W-1:0] bank_index;
    logic [WORD_W-1:0] bank_drive;
    logic [WORD_W-1:0] bank_output_enable;
  } gpiorb_res_t;

  function automatic logic [WORD_W-1:0] bank_mask(int unsigned bank, int unsigned pins);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < WORD_W; i++) begin
      m[i] = ((bank * WORD_W) + i) < pins;
    end
    return m;
  endfunction

  function automatic logic [WORD_W-1:0] func_mask(int unsigned idx, int unsigned pins);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < WORD_W; i++) begin
      m[i] = ((idx * (WORD_W / 2)) + (i >> 1)) < pins;
    end
    return m;
  endfunction

endpackage

[sv/gpio_register_block_unit.sv]
// Top level of the GPIO register block: input word register, register file, result register.
// Depends on gpiorb_pkg and gpiorb_regs.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per access: a bus read, a bus
//   write or a pin sample for a bank (in_command, in_word_addr, in_write_data).
//   Result channel (out_valid / out_stall) returns exactly one word per input word:
//   read data, bad-address flag, touched bank and that bank's latch and direction.
//   A word taken into the input register moves on into the result register, which drives
//   out_*; it waits in the input register while the result register holds a stalled word.
//   Throughput: one word per cycle while no result is stalled; the register file does its
//   read-modify-write as the word moves from the input register to the result register.
//   A waiting result does not block the input register: a new word is taken while
//   the result register is full, and in_stall rises only when both are full and
//   out_stall is high. Stalled results hold their value.
//   Reset (rst_n low, synchronous) empties both registers and clears the output
//   latch, direction (all inputs), sampled levels and function select registers.
//   Bits for pins at PIN_COUNT and above are never stored and read as zero.
module gpio_register_block_unit #(
  parameter int unsigned PIN_COUNT = gpiorb_pkg::PIN_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_command,
  input  logic [gpiorb_pkg::ADDR_W-1:0]     in_word_addr,
  input  logic [gpiorb_pkg::WORD_W-1:0]     in_write_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gpiorb_pkg::WORD_W-1:0]     out_read_data,
  output logic                              out_bad_address,
  output logic [gpiorb_pkg::BANK_W-1:0]     out_bank_index,
  output logic [gpiorb_pkg::WORD_W-1:0]     out_bank_drive,
  output logic [gpiorb_pkg::WORD_W-1:0]     out_bank_output_enable
);
  import gpiorb_pkg::*;

  logic              s1_valid_r;
  logic [1:0]        cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [WORD_W-1:0] data_r;
  logic              out_valid_r;
  gpiorb_res_t       res_r;
  gpiorb_res_t       res_nxt;
  logic              advance;
  logic              in_take;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  gpiorb_regs #(
    .PIN_COUNT(PIN_COUNT)
  ) u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(advance),
    .cmd    (cmd_t'(cmd_r)),
    .addr   (addr_r),
    .data   (data_r),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r  <= in_command;
      addr_r <= in_word_addr;
      data_r <= in_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_read_data          = res_r.read_data;
  assign out_bad_address        = res_r.bad_address;
  assign out_bank_index         = res_r.bank_index;
  assign out_bank_drive         = res_r.bank_drive;
  assign out_bank_output_enable = res_r.bank_output_enable;

  a_bad_bank0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.bad_address) |-> (res_r.bank_index == '0))
    else $error("bad access must report bank 0");

  a_bank_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.bank_index != 2'd3))
    else $error("bank index out of range");

  a_advance_free: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("input word did not move into a free result register");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a full pipeline");

endmodule

[sv/gpiorb_regs.sv]
// Register file of the GPIO block: output latch, direction, sampled pins, function select.
// Decodes one word per enabled cycle and returns its result word combinationally.
// Depends on gpiorb_pkg.
module gpiorb_regs #(
  parameter int unsigned PIN_COUNT = gpiorb_pkg::PIN_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step_en,
  input  gpiorb_pkg::cmd_t                    cmd,
  input  logic [gpiorb_pkg::ADDR_W-1:0]       addr,
  input  logic [gpiorb_pkg::WORD_W-1:0]       data,
  output gpiorb_pkg::gpiorb_res_t             res
);
  import gpiorb_pkg::*;

  localparam logic [WORD_W-1:0] BANK_MASK [BANK_CNT] = '{
    bank_mask(0, PIN_COUNT), bank_mask(1, PIN_COUNT), bank_mask(2, PIN_COUNT)
  };
  localparam logic [WORD_W-1:0] FUNC_MASK [FUNC_CNT] = '{
    func_mask(0, PIN_COUNT), func_mask(1, PIN_COUNT), func_mask(2, PIN_COUNT),
    func_mask(3, PIN_COUNT), func_mask(4, PIN_COUNT), func_mask(5, PIN_COUNT)
  };

  logic [WORD_W-1:0] latch_r [BANK_CNT];
  logic [WORD_W-1:0] latch_nxt [BANK_CNT];
  logic [WORD_W-1:0] dir_r [BANK_CNT];
  logic [WORD_W-1:0] dir_nxt [BANK_CNT];
  logic [WORD_W-1:0] samp_r [BANK_CNT];
  logic [WORD_W-1:0] samp_nxt [BANK_CNT];
  logic [WORD_W-1:0] func_r [FUNC_CNT];
  logic [WORD_W-1:0] func_nxt [FUNC_CNT];

  logic [ADDR_W-1:0]     off;
  logic [BANK_W-1:0]     bank;
  logic [FUNC_IDX_W-1:0] fidx;
  logic [WORD_W-1:0]     rd;
  logic                  bad;
  logic                  wr;
  logic [WORD_W-1:0]     cur_latch;
  logic [WORD_W-1:0]     cur_dir;
  logic [WORD_W-1:0]     cur_samp;
  logic [WORD_W-1:0]     cur_mask;
  logic [WORD_W-1:0]     cur_func;
  logic [WORD_W-1:0]     cur_fmask;

  always_comb begin
    cur_latch = latch_r[0];
    cur_dir   = dir_r[0];
    cur_samp  = samp_r[0];
    cur_mask  = BANK_MASK[0];
    for (int unsigned b = 0; b < BANK_CNT; b++) begin
      if (bank == BANK_W'(b)) begin
        cur_latch = latch_r[b];
        cur_dir   = dir_r[b];
        cur_samp  = samp_r[b];
        cur_mask  = BANK_MASK[b];
      end
    end
    cur_func  = func_r[0];
    cur_fmask = FUNC_MASK[0];
    for (int unsigned f = 0; f < FUNC_CNT; f++) begin
      if (fidx == FUNC_IDX_W'(f)) begin
        cur_func  = func_r[f];
        cur_fmask = FUNC_MASK[f];
      end
    end
  end

  always_comb begin
    latch_nxt = latch_r;
    dir_nxt   = dir_r;
    samp_nxt  = samp_r;
    func_nxt  = func_r;
    rd        = '0;
    bad       = 1'b0;
    bank      = '0;
    off       = '0;
    fidx      = '0;
    wr        = (cmd == CMD_WRITE);
    case (cmd)
      CMD_SAMPLE: begin
        if (addr <= SAMPLE_BANK_LAST) begin
          bank = addr[BANK_W-1:0];
          for (int unsigned b = 0; b < BANK_CNT; b++) begin
            if (bank == BANK_W'(b)) samp_nxt[b] = data & BANK_MASK[b];
          end
        end else begin
          bad = 1'b1;
        end
      end
      CMD_READ, CMD_WRITE: begin
        case (addr) inside
          [ADDR_LEVEL:ADDR_LEVEL_LAST]: begin
            off  = addr - ADDR_LEVEL;
            bank = off[BANK_W-1:0];
            if (!wr) rd = ((cur_latch & cur_dir) | (cur_samp & ~cur_dir)) & cur_mask;
          end
          [ADDR_DIR:ADDR_DIR_LAST]: begin
            off  = addr - ADDR_DIR;
            bank = off[BANK_W-1:0];
            if (wr) begin
              for (int unsigned b = 0; b < BANK_CNT; b++) begin
                if (bank == BANK_W'(b)) dir_nxt[b] = data & BANK_MASK[b];
              end
            end else begin
              rd = cur_dir & cur_mask;
            end
          end
          [ADDR_SET:ADDR_SET_LAST]: begin
            off  = addr - ADDR_SET;
            bank = off[BANK_W-1:0];
            if (wr) begin
              for (int unsigned b = 0; b < BANK_CNT; b++) begin
                if (bank == BANK_W'(b)) latch_nxt[b] = (latch_r[b] | data) & BANK_MASK[b];
              end
            end
          end
          [ADDR_CLR:ADDR_CLR_LAST]: begin
            off  = addr - ADDR_CLR;
            bank = off[BANK_W-1:0];
            if (wr) begin
              for (int unsigned b = 0; b < BANK_CNT; b++) begin
                if (bank == BANK_W'(b)) latch_nxt[b] = latch_r[b] & ~data & BANK_MASK[b];
              end
            end
          end
          [ADDR_FUNC:ADDR_FUNC_LAST]: begin
            off  = addr - ADDR_FUNC;
            fidx = off[FUNC_IDX_W-1:0];
            bank = fidx[FUNC_IDX_W-1:1];
            if (wr) begin
              for (int unsigned f = 0; f < FUNC_CNT; f++) begin
                if (fidx == FUNC_IDX_W'(f)) func_nxt[f] = data & FUNC_MASK[f];
              end
            end else begin
              rd = cur_func & cur_fmask;
            end
          end
          default: bad = 1'b1;
        endcase
      end
      default: bad = 1'b1;
    endcase
  end

  always_comb begin
    res.read_data          = rd;
    res.bad_address        = bad;
    res.bank_index         = bank;
    res.bank_drive         = latch_nxt[0];
    res.bank_output_enable = dir_nxt[0];
    for (int unsigned b = 0; b < BANK_CNT; b++) begin
      if (bank == BANK_W'(b)) begin
        res.bank_drive         = latch_nxt[b];
        res.bank_output_enable = dir_nxt[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int unsigned b = 0; b < BANK_CNT; b++) begin
        latch_r[b] <= '0;
        dir_r[b]   <= '0;
        samp_r[b]  <= '0;
      end
      for (int unsigned f = 0; f < FUNC_CNT; f++) begin
        func_r[f] <= '0;
      end
    end else if (step_en) begin
      latch_r <= latch_nxt;
      dir_r   <= dir_nxt;
      samp_r  <= samp_nxt;
      func_r  <= func_nxt;
    end
  end

endmodule
